[design/grid_world_q_table_update_defines.svh]
// assertion macros for the grid world q table checker
`ifndef GRID_WORLD_Q_TABLE_UPDATE_DEFINES_SVH
`define GRID_WORLD_Q_TABLE_UPDATE_DEFINES_SVH

// same-cycle implication, checked at each rising clock edge outside reset
`define GWQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at each rising clock edge outside reset
`define GWQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/gwq_pkg.sv]
// types, constants and helpers for the grid world q table update block
package gwq_pkg;

  // grid storage geometry
  localparam int MAX_COLS = 8;
  localparam int MAX_ROWS = 8;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int POS_W    = 3;
  localparam int POS_LIM  = 1 << POS_W;
  localparam int COLS_LIM = (MAX_COLS < POS_LIM) ? MAX_COLS : POS_LIM;
  localparam int ROWS_LIM = (MAX_ROWS < POS_LIM) ? MAX_ROWS : POS_LIM;

  // value formats
  localparam int Q_W     = 16;
  localparam int NUM_ACT = 4;
  localparam int SIZE_W  = 4;
  localparam int COST_W  = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;
  localparam int DATA_W  = 24;

  // register reset values
  localparam logic [SIZE_W-1:0] COLS_RST = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] ROWS_RST = SIZE_W'(2);
  localparam logic [COST_W-1:0] COST_RST = COST_W'(26);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS = 2'd0,
    CFG_GRID_ROWS = 2'd1,
    CFG_STEP_COST = 2'd2
  } cfg_idx_t;

  // move directions
  typedef enum logic [1:0] {
    ACT_UP    = 2'd0,
    ACT_DOWN  = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_RIGHT = 2'd3
  } action_t;

  // item kind carried on tuser
  typedef enum logic {
    CMD_STEP   = 1'b0,
    CMD_REWARD = 1'b1
  } cmd_t;

  // input item tdata, lowest field last
  typedef struct packed {
    logic [Q_W-1:0]   reward_value;
    logic [POS_W-1:0] cell_row;
    logic [POS_W-1:0] cell_col;
    logic [1:0]       action;
  } in_item_t;

  // result item tdata, lowest field last
  typedef struct packed {
    logic             hit_terminal;
    logic [Q_W-1:0]   q_new;
    logic             q_written;
    logic [POS_W-1:0] agent_row;
    logic [POS_W-1:0] agent_col;
  } out_item_t;

  // one q memory row: four action values
  typedef logic [NUM_ACT-1:0][Q_W-1:0] q_row_t;

  // linear address of cell (col, row)
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] col,
                                                  input logic [POS_W-1:0] row);
    cell_addr = ADDR_W'(int'(col) + MAX_COLS * int'(row));
  endfunction

endpackage

[design/grid_world_q_table_update.sv]
// grid world q table update: reward and q memories with agent position
//
// Input channel (in_*): one item per command. tuser selects the kind: a step
// moves the agent by the action in tdata, a reward write stores reward_value
// for cell (cell_col, cell_row). Result channel (out_*): exactly one item per
// input item, carrying the agent position after the item, whether a q entry
// was written, the value written and whether the target cell was terminal.
// Configuration channel (cfg_*): grid size and step cost, always ready; write
// it only while no item is in flight.
// Timing: an item is taken in ST_IDLE, when the target cell's q row and
// reward are read into registers; in ST_EXEC the max, subtract and saturate
// are done, the old cell's q entry is written back and the result is loaded
// into the output register. One item is in flight at a time. A new item is
// taken while an earlier result still waits in the output register. If the
// receiver stalls, the second item waits in ST_EXEC until the output
// register frees up.
// Reset: both tables read as zero (per-entry valid bits), the agent sits at
// cell (0, 0) and the registers return to 3 columns, 2 rows, cost 26.
module grid_world_q_table_update (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // action[1:0], cell_col[4:2], cell_row[7:5], reward_value[23:8]
  input  logic [gwq_pkg::DATA_W-1:0]     in_tdata,
  // cmd[0]
  input  logic                           in_tuser,
  // result items
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // agent_col[2:0], agent_row[5:3], q_written[6], q_new[22:7], hit_terminal[23]
  output logic [gwq_pkg::DATA_W-1:0]     out_tdata,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gwq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gwq_pkg::CFG_DAT_W-1:0]  cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;

  // configuration registers
  logic [gwq_pkg::SIZE_W-1:0] grid_cols_r;
  logic [gwq_pkg::SIZE_W-1:0] grid_rows_r;
  logic [gwq_pkg::COST_W-1:0] step_cost_r;

  // agent position
  logic [gwq_pkg::POS_W-1:0] pos_col_r;
  logic [gwq_pkg::POS_W-1:0] pos_row_r;

  // memories and their valid bits
  gwq_pkg::q_row_t          q_mem [gwq_pkg::CELLS];
  logic [gwq_pkg::Q_W-1:0]  r_mem [gwq_pkg::CELLS];
  logic [gwq_pkg::CELLS-1:0] q_vld_r;
  logic [gwq_pkg::CELLS-1:0] r_vld_r;

  // item held between read and write-back
  logic                        cmd_r;
  logic [1:0]                  act_r;
  logic [gwq_pkg::ADDR_W-1:0]  wr_cell_r;
  logic                        wr_cell_ok_r;
  logic [gwq_pkg::Q_W-1:0]     rew_in_r;
  logic                        move_ok_r;
  logic [gwq_pkg::POS_W-1:0]   tgt_col_r;
  logic [gwq_pkg::POS_W-1:0]   tgt_row_r;
  gwq_pkg::q_row_t             q_rd_r;
  logic [gwq_pkg::Q_W-1:0]     r_rd_r;
  logic                        q_rd_vld_r;
  logic                        r_rd_vld_r;

  // output register
  logic                        out_tvalid_r;
  gwq_pkg::out_item_t          out_item_r;

  gwq_pkg::in_item_t           in_item;
  logic                        in_acc;
  logic                        commit;
  logic [gwq_pkg::SIZE_W-1:0]  cols_eff;
  logic [gwq_pkg::SIZE_W-1:0]  rows_eff;
  logic [gwq_pkg::SIZE_W-1:0]  tc;
  logic [gwq_pkg::SIZE_W-1:0]  tr;
  logic                        move_ok;
  logic [gwq_pkg::ADDR_W-1:0]  tgt_addr;
  logic [gwq_pkg::ADDR_W-1:0]  old_addr;

  logic signed [gwq_pkg::Q_W-1:0] q0, q1, q2, q3, m01, m23, qmax;
  logic signed [gwq_pkg::Q_W+1:0] diff;
  logic [gwq_pkg::Q_W-1:0]        q_sat;
  logic [gwq_pkg::Q_W-1:0]        rew_tgt;
  logic                           terminal;
  logic [gwq_pkg::Q_W-1:0]        q_new;
  logic                           q_wr;
  gwq_pkg::q_row_t                q_row_wr;
  gwq_pkg::out_item_t             res;

  assign in_item    = gwq_pkg::in_item_t'(in_tdata);
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign commit     = (state_r == ST_EXEC) && (!out_tvalid_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = gwq_pkg::DATA_W'(out_item_r);

  // grid in use, clamped to storage and position width
  always_comb begin
    cols_eff = (int'(grid_cols_r) > gwq_pkg::COLS_LIM) ?
               gwq_pkg::SIZE_W'(gwq_pkg::COLS_LIM) : grid_cols_r;
    rows_eff = (int'(grid_rows_r) > gwq_pkg::ROWS_LIM) ?
               gwq_pkg::SIZE_W'(gwq_pkg::ROWS_LIM) : grid_rows_r;
  end

  // target cell; a step below zero wraps high and fails the bound check
  always_comb begin
    tc = {1'b0, pos_col_r};
    tr = {1'b0, pos_row_r};
    unique case (gwq_pkg::action_t'(in_item.action))
      gwq_pkg::ACT_UP:    tr = tr + 1'b1;
      gwq_pkg::ACT_DOWN:  tr = tr - 1'b1;
      gwq_pkg::ACT_LEFT:  tc = tc - 1'b1;
      gwq_pkg::ACT_RIGHT: tc = tc + 1'b1;
      default:            tc = tc;
    endcase
    move_ok  = (tc < cols_eff) && (tr < rows_eff);
    tgt_addr = gwq_pkg::cell_addr(tc[gwq_pkg::POS_W-1:0], tr[gwq_pkg::POS_W-1:0]);
    old_addr = gwq_pkg::cell_addr(pos_col_r, pos_row_r);
  end

  // max over the target row, minus cost, saturated at the most negative value
  always_comb begin
    q0   = q_rd_vld_r ? $signed(q_rd_r[0]) : '0;
    q1   = q_rd_vld_r ? $signed(q_rd_r[1]) : '0;
    q2   = q_rd_vld_r ? $signed(q_rd_r[2]) : '0;
    q3   = q_rd_vld_r ? $signed(q_rd_r[3]) : '0;
    m01  = (q1 > q0) ? q1 : q0;
    m23  = (q3 > q2) ? q3 : q2;
    qmax = (m23 > m01) ? m23 : m01;
    diff = (gwq_pkg::Q_W+2)'(qmax) - $signed({3'b000, step_cost_r});
    q_sat = (diff < -(18'sd32768)) ? {1'b1, {(gwq_pkg::Q_W-1){1'b0}}} :
            diff[gwq_pkg::Q_W-1:0];
  end

  // result of the item in write-back
  always_comb begin
    rew_tgt  = r_rd_vld_r ? r_rd_r : '0;
    terminal = (cmd_r == gwq_pkg::CMD_STEP) && move_ok_r && (rew_tgt != '0);
    q_wr     = (cmd_r == gwq_pkg::CMD_STEP) && move_ok_r;
    q_new    = !q_wr ? '0 : (terminal ? rew_tgt : q_sat);
    q_row_wr = '0;
    q_row_wr[act_r] = q_new;
    res.hit_terminal = terminal;
    res.q_new        = q_new;
    res.q_written    = q_wr;
    res.agent_col    = (q_wr && !terminal) ? tgt_col_r : pos_col_r;
    res.agent_row    = (q_wr && !terminal) ? tgt_row_r : pos_row_r;
  end

  // control: state, configuration, position, valid bits, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      grid_cols_r  <= gwq_pkg::COLS_RST;
      grid_rows_r  <= gwq_pkg::ROWS_RST;
      step_cost_r  <= gwq_pkg::COST_RST;
      pos_col_r    <= '0;
      pos_row_r    <= '0;
      q_vld_r      <= '0;
      r_vld_r      <= '0;
      out_tvalid_r <= 1'b0;
      out_item_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gwq_pkg::CFG_GRID_COLS: grid_cols_r <= cfg_data[gwq_pkg::SIZE_W-1:0];
          gwq_pkg::CFG_GRID_ROWS: grid_rows_r <= cfg_data[gwq_pkg::SIZE_W-1:0];
          gwq_pkg::CFG_STEP_COST: step_cost_r <= cfg_data[gwq_pkg::COST_W-1:0];
          default:                step_cost_r <= step_cost_r;
        endcase
      end
      // drained with no new result behind it
      if (out_tvalid_r && out_tready && !commit) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state_r      <= ST_IDLE;
            out_tvalid_r <= 1'b1;
            out_item_r   <= res;
            pos_col_r    <= res.agent_col;
            pos_row_r    <= res.agent_row;
            if (q_wr) begin
              q_vld_r[old_addr] <= 1'b1;
            end
            if ((cmd_r == gwq_pkg::CMD_REWARD) && wr_cell_ok_r) begin
              r_vld_r[wr_cell_r] <= 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // item capture and memory reads at the target cell
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r        <= in_tuser;
      act_r        <= in_item.action;
      wr_cell_r    <= gwq_pkg::cell_addr(in_item.cell_col, in_item.cell_row);
      wr_cell_ok_r <= (int'(in_item.cell_col) < gwq_pkg::MAX_COLS) &&
                      (int'(in_item.cell_row) < gwq_pkg::MAX_ROWS);
      rew_in_r     <= in_item.reward_value;
      move_ok_r    <= move_ok;
      tgt_col_r    <= tc[gwq_pkg::POS_W-1:0];
      tgt_row_r    <= tr[gwq_pkg::POS_W-1:0];
      q_rd_r       <= q_mem[tgt_addr];
      r_rd_r       <= r_mem[tgt_addr];
      q_rd_vld_r   <= q_vld_r[tgt_addr];
      r_rd_vld_r   <= r_vld_r[tgt_addr];
    end
  end

  // q write-back; a never-written row takes zeros in the other lanes
  always_ff @(posedge clk) begin
    if (commit && q_wr) begin
      if (q_vld_r[old_addr]) begin
        q_mem[old_addr][act_r] <= q_new;
      end else begin
        q_mem[old_addr] <= q_row_wr;
      end
    end
  end

  // reward write
  always_ff @(posedge clk) begin
    if (commit && (cmd_r == gwq_pkg::CMD_REWARD) && wr_cell_ok_r) begin
      r_mem[wr_cell_r] <= rew_in_r;
    end
  end

endmodule

[design/gwq_chk.sv]
// port-level checker for the grid world q table update block, with its bind
`include "grid_world_q_table_update_defines.svh"

module gwq_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [gwq_pkg::DATA_W-1:0]     in_tdata,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [gwq_pkg::DATA_W-1:0]     out_tdata,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [gwq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [gwq_pkg::CFG_DAT_W-1:0]  cfg_data
);

  // a stalled result item holds
  `GWQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result item changed while stalled")

  // one item in flight: no item taken right after another
  `GWQ_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "item taken during write-back")

  // nothing written means a zero value
  `GWQ_ASSERT_NOW(a_zero_unwritten, out_tvalid && !out_tdata[6], out_tdata[22:7] == 16'h0000, "q_new nonzero without write")

  // a terminal hit always writes the reward
  `GWQ_ASSERT_NOW(a_term_writes, out_tvalid && out_tdata[23], out_tdata[6] && (out_tdata[22:7] != 16'h0000), "terminal hit without reward write")

endmodule

bind grid_world_q_table_update gwq_chk u_gwq_chk (.*);

[tb/sv/grid_world_q_table_update_tb.sv]
// self-checking testbench for the grid world q table update block
module grid_world_q_table_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gwq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  // one command as queued for the input channel
  typedef struct packed {
    cmd_t     kind;
    in_item_t body;
  } command_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  grid_world_q_table_update uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow of the block state and registers
  logic signed [Q_W-1:0] q_mem [CELLS][NUM_ACT] = '{default: '0};
  logic signed [Q_W-1:0] reward_mem [CELLS] = '{default: '0};
  logic [POS_W-1:0] agent_col_r = '0;
  logic [POS_W-1:0] agent_row_r = '0;
  logic [SIZE_W-1:0] grid_cols_r = COLS_RST;
  logic [SIZE_W-1:0] grid_rows_r = ROWS_RST;
  logic [COST_W-1:0] step_cost_r = COST_RST;

  command_t pending_cmd_q[$];
  out_item_t move_outcome_q[$];

  int failures = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  logic in_taken = 1'b0;
  command_t next_cmd;
  out_item_t got_item;
  out_item_t want_item;
  out_item_t new_outcome;

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // apply one command to the shadow state and work out its result
  task automatic compute_q_update(input cmd_t kind, input in_item_t it, output out_item_t res);
    int cols;
    int rows;
    int tc;
    int tr;
    int old_cell;
    int new_cell;
    int best;
    int qv;
    int k;
    res = '0;
    if (kind == CMD_REWARD) begin
      if (int'(it.cell_col) < MAX_COLS && int'(it.cell_row) < MAX_ROWS)
        reward_mem[int'(it.cell_col) + MAX_COLS * int'(it.cell_row)] = it.reward_value;
    end else begin
      cols = (int'(grid_cols_r) > COLS_LIM) ? COLS_LIM : int'(grid_cols_r);
      rows = (int'(grid_rows_r) > ROWS_LIM) ? ROWS_LIM : int'(grid_rows_r);
      tc = int'(agent_col_r);
      tr = int'(agent_row_r);
      case (action_t'(it.action))
        ACT_UP:   tr++;
        ACT_DOWN: tr--;
        ACT_LEFT: tc--;
        default:  tc++;
      endcase
      // only the target is checked against the grid in use
      if (tc >= 0 && tr >= 0 && tc < cols && tr < rows) begin
        old_cell = int'(agent_col_r) + MAX_COLS * int'(agent_row_r);
        new_cell = tc + MAX_COLS * tr;
        res.q_written = 1'b1;
        if (reward_mem[new_cell] != 0) begin
          // terminal target: take its reward and stay put
          res.hit_terminal = 1'b1;
          qv = reward_mem[new_cell];
        end else begin
          best = q_mem[new_cell][0];
          for (k = 1; k < NUM_ACT; k++)
            if (q_mem[new_cell][k] > best) best = q_mem[new_cell][k];
          qv = best - int'(step_cost_r);
          if (qv < -32768) qv = -32768;
          agent_col_r = POS_W'(tc);
          agent_row_r = POS_W'(tr);
        end
        q_mem[old_cell][it.action] = Q_W'(qv);
        res.q_new = Q_W'(qv);
      end
    end
    res.agent_col = agent_col_r;
    res.agent_row = agent_row_r;
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // step command with random filler in the unused fields
  function automatic command_t make_step(action_t a);
    command_t c;
    c.body = in_item_t'(DATA_W'($urandom));
    c.kind = CMD_STEP;
    c.body.action = a;
    return c;
  endfunction

  function automatic command_t make_reward(int col, int row, logic [Q_W-1:0] val);
    command_t c;
    c.body = in_item_t'(DATA_W'($urandom));
    c.kind = CMD_REWARD;
    c.body.cell_col = POS_W'(col);
    c.body.cell_row = POS_W'(row);
    c.body.reward_value = val;
    return c;
  endfunction

  // mostly moves, some reward writes biased into the grid in use
  function automatic command_t random_command();
    command_t c;
    int lim;
    c.body = in_item_t'(DATA_W'($urandom));
    c.kind = ($urandom_range(99) < 20) ? CMD_REWARD : CMD_STEP;
    if (c.kind == CMD_REWARD) begin
      if ($urandom_range(1) == 1 && grid_cols_r != 0 && grid_rows_r != 0) begin
        lim = (int'(grid_cols_r) > COLS_LIM) ? COLS_LIM : int'(grid_cols_r);
        c.body.cell_col = POS_W'($urandom_range(lim - 1));
        lim = (int'(grid_rows_r) > ROWS_LIM) ? ROWS_LIM : int'(grid_rows_r);
        c.body.cell_row = POS_W'($urandom_range(lim - 1));
      end
      // mostly clear cells so the agent keeps moving
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: c.body.reward_value = '0;
        6: c.body.reward_value = 16'h8000;
        7: c.body.reward_value = 16'h7fff;
        default: ;
      endcase
    end
    return c;
  endfunction

  // wait until every queued command has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_cmd_q.size() != 0 || in_tvalid || move_outcome_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DAT_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GRID_COLS: grid_cols_r = SIZE_W'(val);
      CFG_GRID_ROWS: grid_rows_r = SIZE_W'(val);
      CFG_STEP_COST: step_cost_r = COST_W'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(int cols, int rows, int cost);
    wait_idle();
    write_register(CFG_GRID_COLS, cols);
    write_register(CFG_GRID_ROWS, rows);
    write_register(CFG_STEP_COST, cost);
  endtask

  task automatic run_phase(int cols, int rows, int cost, int send_pct, int recv_pct,
                           int hold, int n);
    set_grid(cols, rows, cost);
    sender_idle_pct = send_pct;
    receiver_stall_pct = recv_pct;
    hold_request = hold;
    repeat (n) pending_cmd_q.push_back(random_command());
  endtask

  // input driver: changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_taken = 1'b0;
    end else if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (pending_cmd_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_cmd = pending_cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= next_cmd.kind;
        in_tdata <= next_cmd.body;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls and long hold-offs
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left <= hold_request;
      hold_request = 0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // monitor: check results, then record accepted commands
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (move_outcome_q.size() == 0) begin
          $error("result item with no command outstanding");
          failures++;
        end else begin
          want_item = move_outcome_q.pop_front();
          got_item = out_item_t'(out_tdata);
          check_field("agent_col", want_item.agent_col, got_item.agent_col);
          check_field("agent_row", want_item.agent_row, got_item.agent_row);
          check_field("q_written", want_item.q_written, got_item.q_written);
          check_field("q_new", $signed(want_item.q_new), $signed(got_item.q_new));
          check_field("hit_terminal", want_item.hit_terminal, got_item.hit_terminal);
        end
      end
      if (in_tvalid && in_tready) begin
        compute_q_update(cmd_t'(in_tuser), in_item_t'(in_tdata), new_outcome);
        move_outcome_q.push_back(new_outcome);
        in_taken = 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[grid_world_q_table_update] ERROR");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset grid 3x2: refused moves, terminal hits, write outside the grid
    pending_cmd_q.push_back(make_step(ACT_DOWN));
    pending_cmd_q.push_back(make_step(ACT_LEFT));
    pending_cmd_q.push_back(make_reward(7, 7, 16'h7fff));
    pending_cmd_q.push_back(make_reward(1, 0, 16'h8000));
    pending_cmd_q.push_back(make_step(ACT_RIGHT));
    pending_cmd_q.push_back(make_reward(1, 0, 16'h0000));
    pending_cmd_q.push_back(make_step(ACT_RIGHT));
    pending_cmd_q.push_back(make_step(ACT_UP));
    pending_cmd_q.push_back(make_step(ACT_UP));
    pending_cmd_q.push_back(make_reward(0, 1, 16'hffff));
    pending_cmd_q.push_back(make_step(ACT_LEFT));
    pending_cmd_q.push_back(make_reward(0, 1, 16'h0000));
    pending_cmd_q.push_back(make_step(ACT_DOWN));

    // 3x3 with the largest cost: back to the corner, then drive the
    // center cell negative so a move into it saturates
    set_grid(3, 3, 32767);
    repeat (agent_col_r) pending_cmd_q.push_back(make_step(ACT_LEFT));
    repeat (agent_row_r) pending_cmd_q.push_back(make_step(ACT_DOWN));
    pending_cmd_q.push_back(make_step(ACT_RIGHT));
    pending_cmd_q.push_back(make_step(ACT_UP));
    pending_cmd_q.push_back(make_step(ACT_UP));
    pending_cmd_q.push_back(make_step(ACT_DOWN));
    pending_cmd_q.push_back(make_step(ACT_DOWN));
    pending_cmd_q.push_back(make_step(ACT_UP));
    pending_cmd_q.push_back(make_step(ACT_LEFT));
    pending_cmd_q.push_back(make_step(ACT_RIGHT));
    pending_cmd_q.push_back(make_step(ACT_RIGHT));
    pending_cmd_q.push_back(make_step(ACT_LEFT));

    // grid shrunk under the agent: old cell still addressed by position
    set_grid(8, 8, 26);
    pending_cmd_q.push_back(make_step(ACT_RIGHT));
    set_grid(2, 2, 26);
    pending_cmd_q.push_back(make_step(ACT_UP));
    pending_cmd_q.push_back(make_step(ACT_RIGHT));
    pending_cmd_q.push_back(make_step(ACT_LEFT));

    // empty grid refuses every move
    set_grid(0, 5, 26);
    pending_cmd_q.push_back(make_step(ACT_UP));
    pending_cmd_q.push_back(make_step(ACT_RIGHT));

    // random phases over several settings and idle patterns
    run_phase(8, 8, 26, 0, 0, 300, 225);
    run_phase(15, 15, 0, 85, 0, 0, 225);
    run_phase(1, 8, 32767, 0, 85, 0, 225);
    run_phase(5, 3, 100, 33, 33, 0, 225);
    run_phase(8, 1, $urandom_range(32767), 0, 85, 0, 225);
    run_phase(6, 7, $urandom_range(32767), 85, 0, 0, 225);
    wait_idle();

    if (failures == 0) begin
      $display("[grid_world_q_table_update] OK");
    end else begin
      $display("[grid_world_q_table_update] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/gwq_pkg.sv
design/grid_world_q_table_update.sv
design/gwq_chk.sv
tb/sv/grid_world_q_table_update_tb.sv
